[hw/rtl/accel_fifo_magnitude_windows_unit_assert.svh]
// assertion macros for the accelerometer magnitude window unit
`ifndef ACCEL_FIFO_MAGNITUDE_WINDOWS_UNIT_ASSERT_SVH
`define ACCEL_FIFO_MAGNITUDE_WINDOWS_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AFMW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define AFMW_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/afmw_pkg.sv]
// shared constants and types of the accelerometer magnitude window unit
`default_nettype none

package afmw_pkg;

  localparam int unsigned ENTRY_W         = 24;
  localparam int unsigned OUT_W           = 20;
  localparam int unsigned MARKER_BIT      = 0;
  localparam int unsigned WINDOW_LOG2_DEF = 9;
  localparam int unsigned SAMPLE_BITS_DEF = 20;

  // window averages that complete with one magnitude
  typedef struct packed {
    logic             a_valid;
    logic [OUT_W-1:0] a;
    logic             b_valid;
    logic [OUT_W-1:0] b;
  } win_res_t;

endpackage

`default_nettype wire

[hw/rtl/afmw_if.sv]
// valid/ready channel interfaces for fifo entries and magnitude results
`default_nettype none

interface afmw_in_if
  import afmw_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] entry_bytes;

  modport source (output valid, output entry_bytes, input ready);
  modport sink (input valid, input entry_bytes, output ready);
endinterface

interface afmw_out_if
  import afmw_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] accel_x;
  logic signed [OUT_W-1:0] accel_y;
  logic signed [OUT_W-1:0] accel_z;
  logic        [OUT_W-1:0] magnitude;
  logic                    avg_a_valid;
  logic        [OUT_W-1:0] avg_a;
  logic                    avg_b_valid;
  logic        [OUT_W-1:0] avg_b;

  modport source (
    output valid, output accel_x, output accel_y, output accel_z, output magnitude,
    output avg_a_valid, output avg_a, output avg_b_valid, output avg_b, input ready
  );
  modport sink (
    input valid, input accel_x, input accel_y, input accel_z, input magnitude,
    input avg_a_valid, input avg_a, input avg_b_valid, input avg_b, output ready
  );
endinterface

`default_nettype wire

[hw/rtl/afmw_sumsq.sv]
// bit-serial sum of the three axis squares, one multiplier bit per cycle
`default_nettype none

module afmw_sumsq
  import afmw_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [SAMPLE_BITS-1:0]   x_i,
  input  wire logic [SAMPLE_BITS-1:0]   y_i,
  input  wire logic [SAMPLE_BITS-1:0]   z_i,
  output logic                          done_o,
  output logic [2*SAMPLE_BITS-1:0]      sum_o
);

  localparam int unsigned ACC_W = 2 * SAMPLE_BITS;
  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS + 1);

  function automatic logic [SAMPLE_BITS-1:0] mag_of(input logic [SAMPLE_BITS-1:0] v);
    mag_of = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  logic [ACC_W-1:0]       mx_q, my_q, mz_q;
  logic [SAMPLE_BITS-1:0] bx_q, by_q, bz_q;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q;
  logic                   done_q;

  // three partial products join the accumulator each cycle while busy
  assign acc_d = acc_q + (bx_q[0] ? mx_q : '0) + (by_q[0] ? my_q : '0)
               + (bz_q[0] ? mz_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SAMPLE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q  <= ACC_W'(mag_of(x_i));
      my_q  <= ACC_W'(mag_of(y_i));
      mz_q  <= ACC_W'(mag_of(z_i));
      bx_q  <= mag_of(x_i);
      by_q  <= mag_of(y_i);
      bz_q  <= mag_of(z_i);
      acc_q <= '0;
    end else if (busy_q) begin
      mx_q  <= mx_q << 1;
      my_q  <= my_q << 1;
      mz_q  <= mz_q << 1;
      bx_q  <= bx_q >> 1;
      by_q  <= by_q >> 1;
      bz_q  <= bz_q >> 1;
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign sum_o  = acc_q;

endmodule

`default_nettype wire

[hw/rtl/afmw_isqrt.sv]
// restoring integer square root, one root bit per cycle
`default_nettype none

module afmw_isqrt
  import afmw_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [2*SAMPLE_BITS-1:0] radicand_i,
  output logic                          done_o,
  output logic [SAMPLE_BITS-1:0]        root_o
);

  localparam int unsigned ACC_W = 2 * SAMPLE_BITS;
  localparam int unsigned RW    = SAMPLE_BITS;
  localparam int unsigned REM_W = RW + 2;
  localparam int unsigned TRY_W = REM_W + 2;
  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS + 1);

  logic [ACC_W-1:0] n_q;
  logic [REM_W-1:0] rem_q;
  logic [RW-1:0]    root_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [TRY_W-1:0] rem_sh;
  logic [TRY_W-1:0] trial;
  logic [TRY_W-1:0] diff;
  logic             fits;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_q, n_q[ACC_W-1 -: 2]};
  assign trial  = TRY_W'({root_q, 2'b01});
  assign diff   = rem_sh - trial;
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SAMPLE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= n_q << 2;
      rem_q  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[RW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[hw/rtl/afmw_window.sv]
// two magnitude window accumulators, window b offset by half a window
`default_nettype none

module afmw_window
  import afmw_pkg::*;
#(
  parameter int unsigned WINDOW_LOG2 = WINDOW_LOG2_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   add_i,
  input  wire logic [SAMPLE_BITS-1:0] mag_i,
  output win_res_t                    res_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + WINDOW_LOG2;
  localparam logic [WINDOW_LOG2-1:0] HALF = {1'b1, {(WINDOW_LOG2-1){1'b0}}};

  logic [WINDOW_LOG2-1:0] cnt_a_q, cnt_b_q, cnt_a_d, cnt_b_d;
  logic [SUM_W-1:0]       sum_a_q, sum_b_q, sum_a_d, sum_b_d;
  logic                   full_a, full_b;

  assign sum_a_d = sum_a_q + SUM_W'(mag_i);
  assign sum_b_d = sum_b_q + SUM_W'(mag_i);
  assign cnt_a_d = cnt_a_q + 1'b1;
  assign cnt_b_d = cnt_b_q + 1'b1;
  assign full_a  = (cnt_a_d == '0);
  assign full_b  = (cnt_b_d == '0);

  always_comb begin
    res_o.a_valid = full_a;
    res_o.a       = full_a ? OUT_W'(sum_a_d[SUM_W-1:WINDOW_LOG2]) : '0;
    res_o.b_valid = full_b;
    res_o.b       = full_b ? OUT_W'(sum_b_d[SUM_W-1:WINDOW_LOG2]) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= HALF;
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else if (add_i) begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      sum_a_q <= full_a ? '0 : sum_a_d;
      sum_b_q <= full_b ? '0 : sum_b_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/accel_fifo_magnitude_windows_unit.sv]
// Accelerometer FIFO vector magnitude with two overlapping window averages.
// in_i takes one 3-byte FIFO entry per item (first byte in bits 23:16, bit 0
// marks an X entry); entries run X, Y, Z and a marked entry restarts as X.
// out_o gives one item per completed triplet: the three sign-extended axis
// samples, floor(sqrt(x*x+y*y+z*z)) and the window averages that completed.
// X and Y entries are only held in registers. A Z entry starts a bit-serial
// square-sum (one multiplier bit per cycle for all three axes) and then a
// restoring square root (one root bit per cycle); the result goes into the
// output register once the root is done and the register is free, and in_i
// is ready again as the result is loaded.
// The output register parts the channels: X and Y entries are still taken
// while a result waits; a finished Z result that finds the register full
// waits inside the block, with in_i not ready, until out_o.ready frees it.
// Reset clears the axis order (expecting X), the held samples, both window
// sums, window A's count and starts window B's count at half a window.
`default_nettype none
`include "accel_fifo_magnitude_windows_unit_assert.svh"

module accel_fifo_magnitude_windows_unit
  import afmw_pkg::*;
#(
  parameter int unsigned WINDOW_LOG2 = WINDOW_LOG2_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  afmw_in_if.sink    in_i,
  afmw_out_if.source out_o
);

  typedef enum logic [1:0] {PH_X, PH_Y, PH_Z} phase_e;
  typedef enum logic [1:0] {ST_IDLE, ST_SQ, ST_RT, ST_OUT} state_e;

  phase_e  phase_q;
  state_e  state_q;

  logic [SAMPLE_BITS-1:0]   held_x_q, held_y_q, z_q;
  logic [SAMPLE_BITS-1:0]   sample;
  logic                     marker;
  logic                     in_accept;
  logic                     is_z;
  logic                     sq_done, rt_done;
  logic [2*SAMPLE_BITS-1:0] sq_sum;
  logic [SAMPLE_BITS-1:0]   root;
  logic                     out_free;
  logic                     load;
  win_res_t                 win_res;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] ax_q, ay_q, az_q;
  logic        [OUT_W-1:0] mag_q;
  win_res_t                win_q;

  assign sample    = in_i.entry_bytes[ENTRY_W-1 -: SAMPLE_BITS];
  assign marker    = in_i.entry_bytes[MARKER_BIT];
  assign in_accept = in_i.valid && in_i.ready;
  assign is_z      = !marker && (phase_q == PH_Z);
  assign out_free  = !out_valid_q || out_o.ready;
  assign load      = ((state_q == ST_RT && rt_done) || state_q == ST_OUT) && out_free;

  assign in_i.ready = (state_q == ST_IDLE);

  afmw_sumsq #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_sumsq (
    .clk_i,
    .rst_ni,
    .start_i(in_accept && is_z),
    .x_i    (held_x_q),
    .y_i    (held_y_q),
    .z_i    (sample),
    .done_o (sq_done),
    .sum_o  (sq_sum)
  );

  afmw_isqrt #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_isqrt (
    .clk_i,
    .rst_ni,
    .start_i   (sq_done),
    .radicand_i(sq_sum),
    .done_o    (rt_done),
    .root_o    (root)
  );

  afmw_window #(
    .WINDOW_LOG2(WINDOW_LOG2),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk_i,
    .rst_ni,
    .add_i(load),
    .mag_i(root),
    .res_o(win_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_X;
      state_q     <= ST_IDLE;
      held_x_q    <= '0;
      held_y_q    <= '0;
      z_q         <= '0;
      out_valid_q <= 1'b0;
      ax_q        <= '0;
      ay_q        <= '0;
      az_q        <= '0;
      mag_q       <= '0;
      win_q       <= '0;
    end else begin
      if (in_accept) begin
        if (marker || phase_q == PH_X) begin
          held_x_q <= sample;
          phase_q  <= PH_Y;
        end else if (phase_q == PH_Y) begin
          held_y_q <= sample;
          phase_q  <= PH_Z;
        end else begin
          z_q     <= sample;
          phase_q <= PH_X;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept && is_z) state_q <= ST_SQ;
        end
        ST_SQ: begin
          if (sq_done) state_q <= ST_RT;
        end
        ST_RT: begin
          if (rt_done) state_q <= out_free ? ST_IDLE : ST_OUT;
        end
        ST_OUT: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase

      // output register, loaded when the root is ready and the slot is free
      if (load) begin
        out_valid_q <= 1'b1;
        ax_q        <= OUT_W'($signed(held_x_q));
        ay_q        <= OUT_W'($signed(held_y_q));
        az_q        <= OUT_W'($signed(z_q));
        mag_q       <= OUT_W'(root);
        win_q       <= win_res;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.accel_x     = ax_q;
  assign out_o.accel_y     = ay_q;
  assign out_o.accel_z     = az_q;
  assign out_o.magnitude   = mag_q;
  assign out_o.avg_a_valid = win_q.a_valid;
  assign out_o.avg_a       = win_q.a;
  assign out_o.avg_b_valid = win_q.b_valid;
  assign out_o.avg_b       = win_q.b;

  `AFMW_ASSERT_IMP(a_sq_done_in_sq, clk_i, rst_ni, sq_done, state_q == ST_SQ,
                   "square sum finished outside its phase")
  `AFMW_ASSERT_IMP(a_rt_done_in_rt, clk_i, rst_ni, rt_done, state_q == ST_RT,
                   "square root finished outside its phase")
  `AFMW_ASSERT_NXT(a_z_starts_sq, clk_i, rst_ni, in_accept && is_z,
                   state_q == ST_SQ && phase_q == PH_X, "z entry did not start the square sum")
  `AFMW_ASSERT_IMP(a_windows_apart, clk_i, rst_ni, load && win_res.a_valid,
                   !win_res.b_valid, "both windows completed on one sample")

endmodule

`default_nettype wire
